// File: sv/edf_periodic_job_scheduler_macros.svh
// assertion helpers shared by the scheduler rtl
`ifndef EDF_PERIODIC_JOB_SCHEDULER_MACROS_SVH
`define EDF_PERIODIC_JOB_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS
// condition that must hold at every clock edge out of reset
`define EPJS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// implication checked at every clock edge out of reset
`define EPJS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define EPJS_ASSERT_ALWAYS(label, cond, msg)
`define EPJS_ASSERT_IMPLIES(label, ante, cons, msg)
`endif

`endif

// File: sv/epjs_pkg.sv
package epjs_pkg;

    localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;
    localparam logic [18:0] COUNT_MAX = 19'h7_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD,
        ST_SEL,
        ST_UPD,
        ST_OUT
    } state_t;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_TICK = 1'b1
    } kind_t;

    // one task slot as held in the task ram
    typedef struct packed {
        logic [15:0] exec_time;
        logic [15:0] period;
        logic [15:0] jobs_left;
        logic [15:0] remaining;
        logic [31:0] deadline;
        logic [15:0] phase;      // current time modulo period
    } entry_t;

    // earliest deadline first, then least remaining time
    function automatic logic job_before(
        input logic [31:0] dl_a,
        input logic [15:0] rem_a,
        input logic [31:0] dl_b,
        input logic [15:0] rem_b
    );
        return (dl_a < dl_b) || ((dl_a == dl_b) && (rem_a < rem_b));
    endfunction

endpackage

// File: sv/edf_periodic_job_scheduler.sv
// channel  dir  handshake                     payload
// item     in   item_valid / item_stall       kind task_index exec_time period job_count
// result   out  result_valid / result_stall   running_valid running_task completed_valid
//                                             completed_task terminated_mask preempted
//                                             jobs_completed jobs_terminated all_done
//
// tick item: two passes over the task ram at one slot per cycle
// load item: when period is nonzero, first the bit-serial time-modulo-period
// remainder, then one selection pass over the task ram
// one item at a time; item_stall is high from acceptance until the result is registered
// the result register holds while result_stall is high; the next item is taken meanwhile
// rst_n clears time, totals and the loaded, pending and jobs-left bits; the ram is not cleared
module edf_periodic_job_scheduler #(
    parameter int TASKS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        kind,
    input  logic [2:0]  task_index,
    input  logic [15:0] exec_time,
    input  logic [15:0] period,
    input  logic [15:0] job_count,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        running_valid,
    output logic [2:0]  running_task,
    output logic        completed_valid,
    output logic [2:0]  completed_task,
    output logic [7:0]  terminated_mask,
    output logic        preempted,
    output logic [18:0] jobs_completed,
    output logic [18:0] jobs_terminated,
    output logic        all_done
);

    import epjs_pkg::*;

    `include "edf_periodic_job_scheduler_macros.svh"

    localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int CW = $clog2(TASKS + 1);
    localparam int EW = $bits(entry_t);

    state_t            state_reg, state_next;

    logic [31:0]       time_reg, time_next;
    logic              time_sat_reg, time_sat_next;
    logic              tick_reg, tick_next;

    logic [2:0]        ld_idx_reg, ld_idx_next;
    logic [15:0]       ld_exec_reg, ld_exec_next;
    logic [15:0]       ld_period_reg, ld_period_next;
    logic [15:0]       ld_count_reg, ld_count_next;

    logic [4:0]        div_cnt_reg, div_cnt_next;
    logic [31:0]       div_dvd_reg, div_dvd_next;
    logic [15:0]       div_rem_reg, div_rem_next;

    logic [CW-1:0]     scan_cnt_reg, scan_cnt_next;
    logic              proc_valid_reg, proc_valid_next;
    logic [IW-1:0]     proc_idx_reg, proc_idx_next;

    logic              best_valid_reg, best_valid_next;
    logic [IW-1:0]     best_idx_reg, best_idx_next;
    logic [31:0]       best_dl_reg, best_dl_next;
    logic [15:0]       best_rem_reg, best_rem_next;

    logic              sel_valid_reg, sel_valid_next;
    logic [IW-1:0]     sel_idx_reg, sel_idx_next;
    logic              ran_reg, ran_next;
    logic              done_valid_reg, done_valid_next;
    logic [IW-1:0]     done_task_reg, done_task_next;
    logic [7:0]        mask_reg, mask_next;

    logic [TASKS-1:0]  loaded_reg, loaded_next;
    logic [TASKS-1:0]  pending_reg, pending_next;
    logic [TASKS-1:0]  has_left_reg, has_left_next;

    logic [18:0]       comp_cnt_reg, comp_cnt_next;
    logic [18:0]       term_cnt_reg, term_cnt_next;

    logic              result_valid_reg, result_valid_next;
    logic              running_valid_reg, running_valid_next;
    logic [2:0]        running_task_reg, running_task_next;
    logic              completed_valid_reg, completed_valid_next;
    logic [2:0]        completed_task_reg, completed_task_next;
    logic [7:0]        terminated_mask_reg, terminated_mask_next;
    logic              preempted_reg, preempted_next;
    logic [18:0]       jobs_completed_reg, jobs_completed_next;
    logic [18:0]       jobs_terminated_reg, jobs_terminated_next;
    logic              all_done_reg, all_done_next;

    // sequencer controls
    logic              in_range;
    logic              scan_active;
    logic              scan_issue;
    logic              scan_done;
    logic              out_free;
    logic              ram_wr_en;
    logic [IW-1:0]     ram_wr_addr;
    entry_t            ram_wr_data;
    entry_t            rd_entry;
    logic [EW-1:0]     rd_bits;

    // divider step
    logic [16:0]       div_trial;
    logic              div_ge;

    // slot written by a load
    logic [IW-1:0]     ld_slot;
    entry_t            load_entry;

    // per-slot update during the second tick pass
    logic              upd_pend;
    logic              upd_drop;
    logic              upd_active;
    logic              upd_release;
    logic              upd_term;
    logic [15:0]       upd_phase;
    logic [16:0]       upd_phase_inc;
    logic [32:0]       upd_dl_sum;
    entry_t            upd_entry;
    logic [7:0]        upd_mask_bit;

    logic              preempt_now;
    logic              all_done_now;

    assign in_range = (32'(task_index) < TASKS);
    assign ld_slot  = IW'(ld_idx_reg);

    epjs_ram #(
        .WIDTH (EW),
        .DEPTH (TASKS)
    ) u_task_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (scan_cnt_reg[IW-1:0]),
        .rd_data (rd_bits)
    );

    assign rd_entry = entry_t'(rd_bits);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (kind == KIND_TICK || !in_range)
                    begin
                        state_next = ST_SEL;
                    end
                    else if (period != 16'd0)
                    begin
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == 5'd0)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_SEL;
            end
            ST_SEL:
            begin
                if (scan_done)
                begin
                    state_next = tick_reg ? ST_UPD : ST_OUT;
                end
            end
            ST_UPD:
            begin
                if (scan_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        item_stall  = (state_reg != ST_IDLE);
        scan_active = (state_reg == ST_SEL) || (state_reg == ST_UPD);
        scan_issue  = scan_active && (scan_cnt_reg < CW'(TASKS));
        scan_done   = scan_active && !scan_issue && !proc_valid_reg;
        out_free    = !result_valid_reg || !result_stall;
        ram_wr_en   = 1'b0;
        ram_wr_addr = proc_idx_reg;
        ram_wr_data = upd_entry;
        unique case (state_reg)
            ST_LOAD:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = ld_slot;
                ram_wr_data = load_entry;
            end
            ST_UPD:
            begin
                ram_wr_en = proc_valid_reg && loaded_reg[proc_idx_reg];
            end
            ST_IDLE, ST_DIV, ST_SEL, ST_OUT:
            begin
                ram_wr_en = 1'b0;
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    // one remainder bit per cycle
    always_comb
    begin
        div_trial = {div_rem_reg, div_dvd_reg[31]};
        div_ge    = (div_trial >= {1'b0, ld_period_reg});
    end

    always_comb
    begin
        load_entry.exec_time = ld_exec_reg;
        load_entry.period    = ld_period_reg;
        load_entry.jobs_left = (ld_count_reg != 16'd0) ? (ld_count_reg - 16'd1) : 16'd0;
        load_entry.remaining = ld_exec_reg;
        load_entry.deadline  = 32'(ld_period_reg);
        load_entry.phase     = (ld_period_reg != 16'd0) ? div_rem_reg : 16'd0;
    end

    // run or complete the selected job, drop late jobs, then release
    always_comb
    begin
        upd_entry = rd_entry;
        upd_pend  = pending_reg[proc_idx_reg];
        if (sel_valid_reg && (proc_idx_reg == sel_idx_reg))
        begin
            if (rd_entry.remaining <= 16'd1)
            begin
                upd_pend = 1'b0;
            end
            else
            begin
                upd_entry.remaining = rd_entry.remaining - 16'd1;
            end
        end
        upd_drop = upd_pend && (rd_entry.deadline <= time_reg);
        if (upd_drop)
        begin
            upd_pend = 1'b0;
        end
        upd_active    = loaded_reg[proc_idx_reg] && (rd_entry.period != 16'd0);
        upd_phase_inc = {1'b0, rd_entry.phase} + 17'd1;
        upd_phase     = rd_entry.phase;
        if (upd_active && !time_sat_reg)
        begin
            upd_phase = (upd_phase_inc == {1'b0, rd_entry.period}) ? 16'd0
                                                                     : upd_phase_inc[15:0];
        end
        upd_entry.phase = upd_phase;
        upd_release = upd_active && (rd_entry.jobs_left != 16'd0) && (upd_phase == 16'd0);
        upd_term    = upd_drop || (upd_release && upd_pend);
        upd_dl_sum  = {1'b0, time_reg} + 33'(rd_entry.period);
        if (upd_release)
        begin
            upd_entry.jobs_left = rd_entry.jobs_left - 16'd1;
            upd_entry.remaining = rd_entry.exec_time;
            upd_entry.deadline  = upd_dl_sum[32] ? TIME_MAX : upd_dl_sum[31:0];
            upd_pend            = 1'b1;
        end
        for (int j = 0; j < 8; j++)
        begin
            upd_mask_bit[j] = upd_term && (32'(proc_idx_reg) == j);
        end
    end

    assign preempt_now  = ran_reg && pending_reg[sel_idx_reg] && (best_idx_reg != sel_idx_reg);
    assign all_done_now = !(|pending_reg) && !(|(loaded_reg & has_left_reg));

    // datapath next values
    always_comb
    begin
        time_next            = time_reg;
        time_sat_next        = time_sat_reg;
        tick_next            = tick_reg;
        ld_idx_next          = ld_idx_reg;
        ld_exec_next         = ld_exec_reg;
        ld_period_next       = ld_period_reg;
        ld_count_next        = ld_count_reg;
        div_cnt_next         = div_cnt_reg;
        div_dvd_next         = div_dvd_reg;
        div_rem_next         = div_rem_reg;
        scan_cnt_next        = scan_cnt_reg;
        proc_valid_next      = scan_issue;
        proc_idx_next        = scan_cnt_reg[IW-1:0];
        best_valid_next      = best_valid_reg;
        best_idx_next        = best_idx_reg;
        best_dl_next         = best_dl_reg;
        best_rem_next        = best_rem_reg;
        sel_valid_next       = sel_valid_reg;
        sel_idx_next         = sel_idx_reg;
        ran_next             = ran_reg;
        done_valid_next      = done_valid_reg;
        done_task_next       = done_task_reg;
        mask_next            = mask_reg;
        loaded_next          = loaded_reg;
        pending_next         = pending_reg;
        has_left_next        = has_left_reg;
        comp_cnt_next        = comp_cnt_reg;
        term_cnt_next        = term_cnt_reg;
        result_valid_next    = result_valid_reg && result_stall;
        running_valid_next   = running_valid_reg;
        running_task_next    = running_task_reg;
        completed_valid_next = completed_valid_reg;
        completed_task_next  = completed_task_reg;
        terminated_mask_next = terminated_mask_reg;
        preempted_next       = preempted_reg;
        jobs_completed_next  = jobs_completed_reg;
        jobs_terminated_next = jobs_terminated_reg;
        all_done_next        = all_done_reg;

        if (scan_issue)
        begin
            scan_cnt_next = scan_cnt_reg + CW'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    tick_next       = (kind == KIND_TICK);
                    ld_idx_next     = task_index;
                    ld_exec_next    = exec_time;
                    ld_period_next  = period;
                    ld_count_next   = job_count;
                    div_cnt_next    = 5'd31;
                    div_dvd_next    = time_reg;
                    div_rem_next    = 16'd0;
                    scan_cnt_next   = '0;
                    best_valid_next = 1'b0;
                    sel_valid_next  = 1'b0;
                    ran_next        = 1'b0;
                    done_valid_next = 1'b0;
                    mask_next       = 8'd0;
                    if (kind == KIND_TICK)
                    begin
                        time_sat_next = (time_reg == TIME_MAX);
                        time_next     = (time_reg == TIME_MAX) ? TIME_MAX : time_reg + 32'd1;
                    end
                end
            end
            ST_DIV:
            begin
                div_cnt_next = div_cnt_reg - 5'd1;
                div_dvd_next = {div_dvd_reg[30:0], 1'b0};
                div_rem_next = div_ge ? 16'(div_trial - {1'b0, ld_period_reg}) : div_trial[15:0];
            end
            ST_LOAD:
            begin
                loaded_next[ld_slot]   = 1'b1;
                pending_next[ld_slot]  = 1'b1;
                has_left_next[ld_slot] = (ld_count_reg > 16'd1);
            end
            ST_SEL:
            begin
                if (proc_valid_reg && pending_reg[proc_idx_reg] &&
                    (!best_valid_reg ||
                     job_before(rd_entry.deadline, rd_entry.remaining,
                                best_dl_reg, best_rem_reg)))
                begin
                    best_valid_next = 1'b1;
                    best_idx_next   = proc_idx_reg;
                    best_dl_next    = rd_entry.deadline;
                    best_rem_next   = rd_entry.remaining;
                end
                if (scan_done && tick_reg)
                begin
                    sel_valid_next  = best_valid_reg;
                    sel_idx_next    = best_idx_reg;
                    scan_cnt_next   = '0;
                    best_valid_next = 1'b0;
                    if (best_valid_reg)
                    begin
                        if (best_rem_reg <= 16'd1)
                        begin
                            done_valid_next = 1'b1;
                            done_task_next  = best_idx_reg;
                            comp_cnt_next   = (comp_cnt_reg == COUNT_MAX) ? COUNT_MAX
                                                                          : comp_cnt_reg + 19'd1;
                        end
                        else
                        begin
                            ran_next = 1'b1;
                        end
                    end
                end
            end
            ST_UPD:
            begin
                if (proc_valid_reg && loaded_reg[proc_idx_reg])
                begin
                    pending_next[proc_idx_reg]  = upd_pend;
                    has_left_next[proc_idx_reg] = (upd_entry.jobs_left != 16'd0);
                    mask_next                   = mask_reg | upd_mask_bit;
                    if (upd_term)
                    begin
                        term_cnt_next = (term_cnt_reg == COUNT_MAX) ? COUNT_MAX
                                                                    : term_cnt_reg + 19'd1;
                    end
                    if (upd_pend &&
                        (!best_valid_reg ||
                         job_before(upd_entry.deadline, upd_entry.remaining,
                                    best_dl_reg, best_rem_reg)))
                    begin
                        best_valid_next = 1'b1;
                        best_idx_next   = proc_idx_reg;
                        best_dl_next    = upd_entry.deadline;
                        best_rem_next   = upd_entry.remaining;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    result_valid_next    = 1'b1;
                    running_valid_next   = best_valid_reg;
                    running_task_next    = best_valid_reg ? 3'(best_idx_reg) : 3'd0;
                    completed_valid_next = done_valid_reg;
                    completed_task_next  = done_valid_reg ? 3'(done_task_reg) : 3'd0;
                    terminated_mask_next = mask_reg;
                    preempted_next       = preempt_now;
                    jobs_completed_next  = comp_cnt_reg;
                    jobs_terminated_next = term_cnt_reg;
                    all_done_next        = all_done_now;
                end
            end
            default:
            begin
                result_valid_next = result_valid_reg && result_stall;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            time_reg         <= 32'd0;
            time_sat_reg     <= 1'b0;
            tick_reg         <= 1'b0;
            div_cnt_reg      <= 5'd0;
            scan_cnt_reg     <= '0;
            proc_valid_reg   <= 1'b0;
            best_valid_reg   <= 1'b0;
            sel_valid_reg    <= 1'b0;
            ran_reg          <= 1'b0;
            done_valid_reg   <= 1'b0;
            mask_reg         <= 8'd0;
            loaded_reg       <= '0;
            pending_reg      <= '0;
            has_left_reg     <= '0;
            comp_cnt_reg     <= 19'd0;
            term_cnt_reg     <= 19'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            time_reg         <= time_next;
            time_sat_reg     <= time_sat_next;
            tick_reg         <= tick_next;
            div_cnt_reg      <= div_cnt_next;
            scan_cnt_reg     <= scan_cnt_next;
            proc_valid_reg   <= proc_valid_next;
            best_valid_reg   <= best_valid_next;
            sel_valid_reg    <= sel_valid_next;
            ran_reg          <= ran_next;
            done_valid_reg   <= done_valid_next;
            mask_reg         <= mask_next;
            loaded_reg       <= loaded_next;
            pending_reg      <= pending_next;
            has_left_reg     <= has_left_next;
            comp_cnt_reg     <= comp_cnt_next;
            term_cnt_reg     <= term_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        ld_idx_reg          <= ld_idx_next;
        ld_exec_reg         <= ld_exec_next;
        ld_period_reg       <= ld_period_next;
        ld_count_reg        <= ld_count_next;
        div_dvd_reg         <= div_dvd_next;
        div_rem_reg         <= div_rem_next;
        proc_idx_reg        <= proc_idx_next;
        best_idx_reg        <= best_idx_next;
        best_dl_reg         <= best_dl_next;
        best_rem_reg        <= best_rem_next;
        sel_idx_reg         <= sel_idx_next;
        done_task_reg       <= done_task_next;
        running_valid_reg   <= running_valid_next;
        running_task_reg    <= running_task_next;
        completed_valid_reg <= completed_valid_next;
        completed_task_reg  <= completed_task_next;
        terminated_mask_reg <= terminated_mask_next;
        preempted_reg       <= preempted_next;
        jobs_completed_reg  <= jobs_completed_next;
        jobs_terminated_reg <= jobs_terminated_next;
        all_done_reg        <= all_done_next;
    end

    assign result_valid    = result_valid_reg;
    assign running_valid   = running_valid_reg;
    assign running_task    = running_task_reg;
    assign completed_valid = completed_valid_reg;
    assign completed_task  = completed_task_reg;
    assign terminated_mask = terminated_mask_reg;
    assign preempted       = preempted_reg;
    assign jobs_completed  = jobs_completed_reg;
    assign jobs_terminated = jobs_terminated_reg;
    assign all_done        = all_done_reg;

    `EPJS_ASSERT_ALWAYS(a_pending_loaded, (pending_reg & ~loaded_reg) == '0, "pending slot not loaded")
    `EPJS_ASSERT_IMPLIES(a_div_rem_bound, state_reg == ST_DIV, div_rem_reg < ld_period_reg, "remainder out of range")
    `EPJS_ASSERT_IMPLIES(a_scan_index, proc_valid_reg, 32'(proc_idx_reg) < TASKS, "scan index beyond slots")
    `EPJS_ASSERT_IMPLIES(a_done_idle, result_valid && all_done, !running_valid, "job selected while all done")
    `EPJS_ASSERT_IMPLIES(a_complete_no_preempt, result_valid, !(completed_valid && preempted), "completion and preemption together")

endmodule

// File: sv/epjs_ram.sv
module epjs_ram #(
    parameter int WIDTH = 112,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
